### src/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared constants and types of the 3D voxel traversal unit.
// ----------------------------------------------------------------------------
package vrt_pkg;

   localparam int MAX_CELLS = 64;
   localparam int COORD_W   = 24;
   localparam int CS_W      = 16;
   localparam int DIV_ITERS = COORD_W;
   localparam int IT_W      = $clog2(DIV_ITERS + 1);
   localparam int CNT_W     = $clog2(MAX_CELLS + 1);
   localparam int NC_W      = $clog2(MAX_CELLS) + CS_W + 1;
   localparam int DM_W      = COORD_W + 1;
   localparam int PROD_W    = NC_W + DM_W;
   localparam int TOTAL_W   = COORD_W + 3;

   typedef enum logic [2:0] {
      FE_IDLE,
      FE_DIV,
      FE_FIX,
      FE_MUL,
      FE_PUSH
   } fe_state_type;

   typedef enum logic {
      BE_IDLE,
      BE_RUN
   } be_state_type;

   // p[a][b] = next crossing of a times |d| of b; p[b][b] = cell size times |d| of b
   typedef struct packed {
      logic [2:0][COORD_W-1:0]       g;
      logic [2:0][2:0][PROD_W-1:0]   p;
      logic [2:0]                    inf;
      logic [2:0]                    sgn;
      logic [CNT_W-1:0]              n;
      logic                          cut;
   } seg_type;

endpackage

### src/vrt_front.sv
// ----------------------------------------------------------------------------
// vrt_front
// Accepts a segment, finds start/end cells by serial division, derives the
// crossing products with one shared multiplier, hands the setup to the queue.
// ----------------------------------------------------------------------------
module vrt_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [15:0]                cell_size,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [143:0]               req_tdata,
   output logic                       seg_valid,
   input  logic                       seg_ready,
   output vrt_pkg::seg_type           seg
);
   import vrt_pkg::*;

   fe_state_type                state_ff, state_in;
   logic [IT_W-1:0]             it_ff, it_in;
   logic [1:0]                  ma_ff, ma_in, mb_ff, mb_in;
   logic [CS_W-1:0]             c_ff;
   logic [5:0][COORD_W-1:0]     raw_ff;
   logic [5:0][COORD_W-1:0]     num_ff;
   logic [5:0][CS_W-1:0]        rem_ff;
   logic [5:0][COORD_W-1:0]     num_in;
   logic [5:0][CS_W-1:0]        rem_in;
   logic [2:0][COORD_W-1:0]     g_ff;
   logic [2:0][DM_W-1:0]        dm_ff;
   logic [2:0][CS_W:0]          near_ff;
   logic [2:0]                  inf_ff, sgn_ff;
   logic [CNT_W-1:0]            n_ff;
   logic                        cut_ff;
   logic [2:0][2:0][PROD_W-1:0] p_ff;

   logic [2:0][COORD_W-1:0]     g_fix;
   logic [2:0][DM_W-1:0]        dm_fix;
   logic [2:0][CS_W:0]          near_fix;
   logic [2:0]                  inf_fix, sgn_fix;
   logic [TOTAL_W-1:0]          total_fix;
   logic [CS_W:0]               mul_a;
   logic [DM_W-1:0]             mul_b;
   logic [CS_W+DM_W:0]          mul_p;

   always_comb begin
      logic [CS_W:0] rt;
      for (int i = 0; i < 6; i++) begin
         rt = {rem_ff[i], num_ff[i][COORD_W-1]};
         if (rt >= {1'b0, c_ff}) begin
            rem_in[i] = CS_W'(rt - {1'b0, c_ff});
            num_in[i] = {num_ff[i][COORD_W-2:0], 1'b1};
         end else begin
            rem_in[i] = rt[CS_W-1:0];
            num_in[i] = {num_ff[i][COORD_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      logic signed [COORD_W+1:0] ga, gb, df;
      logic [COORD_W+1:0]        ad;
      logic signed [DM_W-1:0]    d;
      logic [CS_W-1:0]           fr;
      total_fix = TOTAL_W'(1);
      for (int a = 0; a < 3; a++) begin
         ga = raw_ff[a][COORD_W-1]
            ? -$signed({2'b00, num_ff[a]}) - $signed({(COORD_W+1)'(0), rem_ff[a] != '0})
            : $signed({2'b00, num_ff[a]});
         gb = raw_ff[a+3][COORD_W-1]
            ? -$signed({2'b00, num_ff[a+3]})
              - $signed({(COORD_W+1)'(0), rem_ff[a+3] != '0})
            : $signed({2'b00, num_ff[a+3]});
         df = ga - gb;
         ad = df[COORD_W+1] ? 26'(-df) : 26'(df);
         total_fix = total_fix + TOTAL_W'(ad);
         d = $signed({raw_ff[a+3][COORD_W-1], raw_ff[a+3]})
           - $signed({raw_ff[a][COORD_W-1], raw_ff[a]});
         if (!raw_ff[a][COORD_W-1] || rem_ff[a] == '0) begin
            fr = raw_ff[a][COORD_W-1] ? '0 : rem_ff[a];
         end else begin
            fr = c_ff - rem_ff[a];
         end
         g_fix[a]    = ga[COORD_W-1:0];
         sgn_fix[a]  = d[DM_W-1];
         inf_fix[a]  = (d == '0);
         dm_fix[a]   = d[DM_W-1] ? DM_W'(-d) : DM_W'(d);
         near_fix[a] = d[DM_W-1] ? {1'b0, fr} : ({1'b0, c_ff} - {1'b0, fr});
      end
   end

   assign mul_a = (ma_ff == mb_ff) ? {1'b0, c_ff} : near_ff[ma_ff];
   assign mul_b = dm_ff[mb_ff];
   assign mul_p = mul_a * mul_b;

   always_comb begin
      state_in   = state_ff;
      it_in      = it_ff;
      ma_in      = ma_ff;
      mb_in      = mb_ff;
      req_tready = 1'b0;
      seg_valid  = 1'b0;
      case (state_ff)
         FE_IDLE: begin
            req_tready = 1'b1;
            it_in      = '0;
            if (req_tvalid) begin
               state_in = FE_DIV;
            end
         end
         FE_DIV: begin
            it_in = it_ff + IT_W'(1);
            if (it_ff == IT_W'(DIV_ITERS - 1)) begin
               state_in = FE_FIX;
            end
         end
         FE_FIX: begin
            ma_in    = '0;
            mb_in    = '0;
            state_in = FE_MUL;
         end
         FE_MUL: begin
            if (mb_ff == 2'd2) begin
               mb_in = '0;
               ma_in = ma_ff + 2'd1;
               if (ma_ff == 2'd2) begin
                  state_in = FE_PUSH;
               end
            end else begin
               mb_in = mb_ff + 2'd1;
            end
         end
         FE_PUSH: begin
            seg_valid = 1'b1;
            if (seg_ready) begin
               state_in = FE_IDLE;
            end
         end
         default: state_in = FE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
         it_ff    <= '0;
         ma_ff    <= '0;
         mb_ff    <= '0;
      end else begin
         state_ff <= state_in;
         it_ff    <= it_in;
         ma_ff    <= ma_in;
         mb_ff    <= mb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == FE_IDLE && req_tvalid) begin
         c_ff <= (cell_size == '0) ? CS_W'(1) : cell_size;
         for (int i = 0; i < 6; i++) begin
            raw_ff[i] <= req_tdata[COORD_W*i +: COORD_W];
            num_ff[i] <= req_tdata[COORD_W*i+COORD_W-1]
                       ? COORD_W'(-req_tdata[COORD_W*i +: COORD_W])
                       : req_tdata[COORD_W*i +: COORD_W];
            rem_ff[i] <= '0;
         end
      end else if (state_ff == FE_DIV) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
      if (state_ff == FE_FIX) begin
         g_ff    <= g_fix;
         dm_ff   <= dm_fix;
         near_ff <= near_fix;
         inf_ff  <= inf_fix;
         sgn_ff  <= sgn_fix;
         cut_ff  <= total_fix > TOTAL_W'(MAX_CELLS);
         n_ff    <= (total_fix > TOTAL_W'(MAX_CELLS)) ? CNT_W'(MAX_CELLS)
                                                      : total_fix[CNT_W-1:0];
      end
      if (state_ff == FE_MUL) begin
         p_ff[ma_ff][mb_ff] <= PROD_W'(mul_p);
      end
   end

   assign seg.g   = g_ff;
   assign seg.p   = p_ff;
   assign seg.inf = inf_ff;
   assign seg.sgn = sgn_ff;
   assign seg.n   = n_ff;
   assign seg.cut = cut_ff;

endmodule

### src/vrt_queue.sv
// ----------------------------------------------------------------------------
// vrt_queue
// Two-entry queue of segment setups between front and back.
// ----------------------------------------------------------------------------
module vrt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  vrt_pkg::seg_type wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output vrt_pkg::seg_type rd_data
);
   import vrt_pkg::*;

   seg_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = mem_ff[rp_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end

endmodule

### src/vrt_back.sv
// ----------------------------------------------------------------------------
// vrt_back
// DDA walker: emits one cell per beat and advances the earliest-crossing axis.
// ----------------------------------------------------------------------------
module vrt_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             seg_valid,
   output logic             seg_ready,
   input  vrt_pkg::seg_type seg,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [71:0]      rsp_tdata,
   output logic             rsp_tlast,
   output logic             rsp_tuser
);
   import vrt_pkg::*;

   be_state_type                state_ff, state_in;
   logic [2:0][COORD_W-1:0]     g_ff;
   logic [2:0][2:0][PROD_W-1:0] p_ff;
   logic [2:0]                  inf_ff, sgn_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic                        cut_ff;
   logic                        vld_ff, vld_in;
   logic [71:0]                 dat_ff;
   logic                        lst_ff, trc_ff;
   logic                        fire, last;
   logic                        e01, e02, e12;
   logic [1:0]                  ax;

   assign fire = (state_ff == BE_RUN) && (!vld_ff || rsp_tready);
   assign last = (cnt_ff == CNT_W'(1));

   assign e01 = !inf_ff[0] && (inf_ff[1] || p_ff[0][1] < p_ff[1][0]);
   assign e02 = !inf_ff[0] && (inf_ff[2] || p_ff[0][2] < p_ff[2][0]);
   assign e12 = !inf_ff[1] && (inf_ff[2] || p_ff[1][2] < p_ff[2][1]);
   assign ax  = (e01 && e02) ? 2'd0 : (e12 ? 2'd1 : 2'd2);

   always_comb begin
      state_in  = state_ff;
      seg_ready = 1'b0;
      vld_in    = vld_ff && !rsp_tready;
      case (state_ff)
         BE_IDLE: begin
            seg_ready = 1'b1;
            if (seg_valid) state_in = BE_RUN;
         end
         BE_RUN: begin
            if (fire) begin
               vld_in = 1'b1;
               if (last) state_in = BE_IDLE;
            end
         end
         default: state_in = BE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BE_IDLE;
         vld_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         if (state_ff == BE_IDLE && seg_valid) begin
            cnt_ff <= seg.n;
         end else if (fire) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BE_IDLE && seg_valid) begin
         g_ff   <= seg.g;
         p_ff   <= seg.p;
         inf_ff <= seg.inf;
         sgn_ff <= seg.sgn;
         cut_ff <= seg.cut;
      end else if (fire) begin
         dat_ff <= {g_ff[2], g_ff[1], g_ff[0]};
         lst_ff <= last;
         trc_ff <= last && cut_ff;
         if (!last) begin
            g_ff[ax] <= sgn_ff[ax] ? g_ff[ax] - COORD_W'(1) : g_ff[ax] + COORD_W'(1);
            for (int b = 0; b < 3; b++) begin
               if (b != int'(ax)) begin
                  p_ff[ax][b] <= p_ff[ax][b] + p_ff[b][b];
               end
            end
         end
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = dat_ff;
   assign rsp_tlast  = lst_ff;
   assign rsp_tuser  = trc_ff;

   a_run_has_cells: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BE_RUN) |-> (cnt_ff != '0))
      else $error("walker running with no cells left");
   a_trunc_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("truncation flag off the final cell");
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (fire && last) |=> (state_ff == BE_IDLE))
      else $error("walker did not stop after final cell");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled cell changed");

endmodule

### src/voxel_ray_traversal_3d_unit.sv
// ----------------------------------------------------------------------------
// voxel_ray_traversal_3d_unit
// 3D grid traversal of a segment; one cell index per result beat.
// ----------------------------------------------------------------------------
// Path from accepted segment to first cell: 24-step serial division, 9 shared
// multiplies, queue and output register.
// Throughput: one cell per cycle while walking, unless rsp_tready stalls the output;
// a new segment's setup overlaps the previous walk through a two-entry queue.
// Reset: synchronous, clears control state and sets cell size to 256.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_3d_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,   // src_x, src_y, src_z, dst_x, dst_y, dst_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,   // cell_x, cell_y, cell_z
   output logic         rsp_tlast,   // last_cell
   output logic         rsp_tuser    // truncated
);
   import vrt_pkg::*;

   logic [CS_W-1:0] cell_size_ff;
   seg_type         f_seg, b_seg;
   logic            f_valid, f_ready, b_valid, b_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff <= CS_W'(256);
      end else if (csr_wr_en) begin
         cell_size_ff <= csr_wr_data;
      end
   end

   vrt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cell_size  (cell_size_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .seg_valid  (f_valid),
      .seg_ready  (f_ready),
      .seg        (f_seg)
   );

   vrt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (f_valid),
      .wr_ready (f_ready),
      .wr_data  (f_seg),
      .rd_valid (b_valid),
      .rd_ready (b_ready),
      .rd_data  (b_seg)
   );

   vrt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .seg_valid  (b_valid),
      .seg_ready  (b_ready),
      .seg        (b_seg),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
